FILE: rtl/pwfd_pkg.sv
`default_nettype none
package pwfd_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned StepW  = 4;
  localparam int unsigned PeriodW = 17;
  localparam int unsigned RateW  = 31;
  localparam int unsigned LimitW = 31;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_PROP_GAIN          = 3'd0,
    REG_INTEGRAL_GAIN      = 3'd1,
    REG_DERIV_GAIN         = 3'd2,
    REG_TARGET_RATE_GAIN   = 3'd3,
    REG_FEEDBACK_RATE_GAIN = 3'd4,
    REG_PERIOD             = 3'd5,
    REG_RATE               = 3'd6,
    REG_INTEGRAL_LIMIT     = 3'd7
  } reg_idx_t;

  // product selected for the shared multiplier; also names its write-back target
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_TD   = 4'd1,
    OP_FD   = 4'd2,
    OP_TRT  = 4'd3,
    OP_FRT  = 4'd4,
    OP_ED   = 4'd5,
    OP_KIE  = 4'd6,
    OP_PT   = 4'd7,
    OP_IP   = 4'd8,
    OP_DT   = 4'd9
  } mul_op_t;

  typedef struct packed {
    logic    capture;   // latch the accepted item
    mul_op_t mul_op;    // operands for the multiplier this cycle
    logic    err_en;    // form the error from the rate terms
    logic    integ_en;  // accumulate, clamp and gate the integral
    logic    load;      // final sum into the result register, update history
  } dp_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/pwfd_in_if.sv
`default_nettype none
interface pwfd_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  target;
  logic signed [31:0]  measured;
  logic                integ_enable;

  modport source (output valid, output target, output measured, output integ_enable,
                  input ready);
  modport sink   (input valid, input target, input measured, input integ_enable,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/pwfd_out_if.sv
`default_nettype none
interface pwfd_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  drive;
  logic signed [31:0]  prop_term;
  logic signed [31:0]  deriv_term;
  logic signed [31:0]  integral_term;
  logic signed [31:0]  target_rate_term;
  logic signed [31:0]  feedback_rate_term;

  modport source (output valid, output drive, output prop_term, output deriv_term,
                  output integral_term, output target_rate_term,
                  output feedback_rate_term, input ready);
  modport sink   (input valid, input drive, input prop_term, input deriv_term,
                  input integral_term, input target_rate_term,
                  input feedback_rate_term, output ready);
endinterface
`default_nettype wire

FILE: rtl/pwfd_ctrl.sv
`default_nettype none
module pwfd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pwfd_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  localparam logic [pwfd_pkg::StepW-1:0] LastStep = 4'd11;

  state_t                        state_r, state_nxt;
  logic [pwfd_pkg::StepW-1:0]    step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == S_LOAD) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = S_RUN;
      end
      S_RUN: begin
        step_nxt = step_r + 4'd1;
        if (step_r == LastStep) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // schedule: a product is written back in the cycle after it is issued
  always_comb begin
    cmd          = '0;
    cmd.mul_op   = pwfd_pkg::OP_NONE;
    cmd.capture  = in_ready && in_valid;
    cmd.load     = load;
    if (state_r == S_RUN) begin
      case (step_r)
        4'd0:    cmd.mul_op = pwfd_pkg::OP_TD;
        4'd1:    cmd.mul_op = pwfd_pkg::OP_FD;
        4'd2:    cmd.mul_op = pwfd_pkg::OP_TRT;
        4'd3:    cmd.mul_op = pwfd_pkg::OP_FRT;
        4'd5:    cmd.err_en = 1'b1;
        4'd6:    cmd.mul_op = pwfd_pkg::OP_ED;
        4'd7:    cmd.mul_op = pwfd_pkg::OP_KIE;
        4'd8:    cmd.mul_op = pwfd_pkg::OP_PT;
        4'd9:    cmd.mul_op = pwfd_pkg::OP_IP;
        4'd10:   cmd.mul_op = pwfd_pkg::OP_DT;
        4'd11:   cmd.integ_en = 1'b1;
        default: cmd.mul_op = pwfd_pkg::OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pwfd_dp.sv
`default_nettype none
module pwfd_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [pwfd_pkg::RegIdxW-1:0]       cfg_index,
  input  wire logic [pwfd_pkg::DataW-1:0]         cfg_wdata,
  input  wire pwfd_pkg::dp_cmd_t                  cmd,
  input  wire logic signed [pwfd_pkg::DataW-1:0]  target,
  input  wire logic signed [pwfd_pkg::DataW-1:0]  measured,
  input  wire logic                               integ_enable,
  output logic signed [pwfd_pkg::DataW-1:0]       drive,
  output logic signed [pwfd_pkg::DataW-1:0]       prop_term,
  output logic signed [pwfd_pkg::DataW-1:0]       deriv_term,
  output logic signed [pwfd_pkg::DataW-1:0]       integral_term,
  output logic signed [pwfd_pkg::DataW-1:0]       target_rate_term,
  output logic signed [pwfd_pkg::DataW-1:0]       feedback_rate_term
);

  localparam int unsigned OpW   = pwfd_pkg::DataW + 1;
  localparam int unsigned ProdW = 2 * OpW;

  function automatic logic signed [ProdW-1:0] sx(input logic signed [31:0] v);
    logic signed [ProdW-1:0] r;
    r = v;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [31:0] r;
    if (v > sx(32'sh7fffffff))      r = 32'sh7fffffff;
    else if (v < sx(32'sh80000000)) r = 32'sh80000000;
    else                            r = v[31:0];
    return r;
  endfunction

  // configuration
  logic signed [31:0]               kp_r, ki_r, kd_r, tkg_r, fkg_r;
  logic [pwfd_pkg::PeriodW-1:0]     per_r;
  logic [pwfd_pkg::RateW-1:0]       hz_r;
  logic [pwfd_pkg::LimitW-1:0]      lim_r;

  // item and history
  logic signed [31:0]  tgt_r, meas_r;
  logic                en_r;
  logic signed [31:0]  prev_tgt_r, prev_meas_r, prev_err_r, integ_r;

  // intermediates
  logic signed [31:0]  td_r, fd_r, trt_r, frt_r, err_r, ed_r, kie_r, pt_r, ip_r, dt_r;

  // multiplier
  logic signed [OpW-1:0]    mul_a, mul_b;
  logic signed [ProdW-1:0]  prod_c, prod_r, rnd_c;
  logic signed [31:0]       q_c;
  pwfd_pkg::mul_op_t        wb_op_r;

  logic signed [31:0]  err_c, acc_c, lim_s, drive_c;
  logic signed [31:0]  drive_r, pt_out_r, dt_out_r, integ_out_r, trt_out_r, frt_out_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      pwfd_pkg::OP_TD: begin
        mul_a = {prev_tgt_r[31], prev_tgt_r} - {tgt_r[31], tgt_r};
        mul_b = {2'b00, hz_r};
      end
      pwfd_pkg::OP_FD: begin
        mul_a = {prev_meas_r[31], prev_meas_r} - {meas_r[31], meas_r};
        mul_b = {2'b00, hz_r};
      end
      pwfd_pkg::OP_TRT: begin
        mul_a = {td_r[31], td_r};
        mul_b = {tkg_r[31], tkg_r};
      end
      pwfd_pkg::OP_FRT: begin
        mul_a = {fd_r[31], fd_r};
        mul_b = {fkg_r[31], fkg_r};
      end
      pwfd_pkg::OP_ED: begin
        mul_a = {prev_err_r[31], prev_err_r} - {err_r[31], err_r};
        mul_b = {2'b00, hz_r};
      end
      pwfd_pkg::OP_KIE: begin
        mul_a = {ki_r[31], ki_r};
        mul_b = {err_r[31], err_r};
      end
      pwfd_pkg::OP_PT: begin
        mul_a = {err_r[31], err_r};
        mul_b = {kp_r[31], kp_r};
      end
      pwfd_pkg::OP_IP: begin
        mul_a = {kie_r[31], kie_r};
        mul_b = {16'b0, per_r};
      end
      pwfd_pkg::OP_DT: begin
        mul_a = {ed_r[31], ed_r};
        mul_b = {kd_r[31], kd_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // round half up, drop 16 fraction bits, saturate
  assign rnd_c = (prod_r + ProdW'(32768)) >>> 16;
  assign q_c   = sat32(rnd_c);

  assign err_c = sat32(sx(sat32(sx(tgt_r) + sx(trt_r))) - sx(sat32(sx(meas_r) + sx(frt_r))));

  assign lim_s = {1'b0, lim_r};
  always_comb begin
    acc_c = sat32(sx(integ_r) + sx(ip_r));
    if (acc_c > lim_s) acc_c = lim_s;
    if (acc_c < -lim_s) acc_c = -lim_s;
    if (!en_r) acc_c = '0;
  end

  assign drive_c = sat32(sx(pt_r) + sx(dt_r) + sx(integ_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      tkg_r       <= '0;
      fkg_r       <= '0;
      per_r       <= '0;
      hz_r        <= '0;
      lim_r       <= '0;
      prev_tgt_r  <= '0;
      prev_meas_r <= '0;
      prev_err_r  <= '0;
      integ_r     <= '0;
      wb_op_r     <= pwfd_pkg::OP_NONE;
    end else begin
      if (cfg_we) begin
        case (pwfd_pkg::reg_idx_t'(cfg_index))
          pwfd_pkg::REG_PROP_GAIN:          kp_r  <= cfg_wdata;
          pwfd_pkg::REG_INTEGRAL_GAIN:      ki_r  <= cfg_wdata;
          pwfd_pkg::REG_DERIV_GAIN:         kd_r  <= cfg_wdata;
          pwfd_pkg::REG_TARGET_RATE_GAIN:   tkg_r <= cfg_wdata;
          pwfd_pkg::REG_FEEDBACK_RATE_GAIN: fkg_r <= cfg_wdata;
          pwfd_pkg::REG_PERIOD:             per_r <= cfg_wdata[pwfd_pkg::PeriodW-1:0];
          pwfd_pkg::REG_RATE:               hz_r  <= cfg_wdata[pwfd_pkg::RateW-1:0];
          pwfd_pkg::REG_INTEGRAL_LIMIT:     lim_r <= cfg_wdata[pwfd_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      wb_op_r <= cmd.mul_op;
      if (cmd.integ_en) integ_r <= acc_c;
      if (cmd.load) begin
        prev_tgt_r  <= tgt_r;
        prev_meas_r <= meas_r;
        prev_err_r  <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_r  <= target;
      meas_r <= measured;
      en_r   <= integ_enable;
    end
    prod_r <= prod_c;
    case (wb_op_r)
      pwfd_pkg::OP_TD:  td_r  <= q_c;
      pwfd_pkg::OP_FD:  fd_r  <= q_c;
      pwfd_pkg::OP_TRT: trt_r <= q_c;
      pwfd_pkg::OP_FRT: frt_r <= q_c;
      pwfd_pkg::OP_ED:  ed_r  <= q_c;
      pwfd_pkg::OP_KIE: kie_r <= q_c;
      pwfd_pkg::OP_PT:  pt_r  <= q_c;
      pwfd_pkg::OP_IP:  ip_r  <= q_c;
      pwfd_pkg::OP_DT:  dt_r  <= q_c;
      default: ;
    endcase
    if (cmd.err_en) err_r <= err_c;
    if (cmd.load) begin
      drive_r     <= drive_c;
      pt_out_r    <= pt_r;
      dt_out_r    <= dt_r;
      integ_out_r <= integ_r;
      trt_out_r   <= trt_r;
      frt_out_r   <= frt_r;
    end
  end

  assign drive              = drive_r;
  assign prop_term          = pt_out_r;
  assign deriv_term         = dt_out_r;
  assign integral_term      = integ_out_r;
  assign target_rate_term   = trt_out_r;
  assign feedback_rate_term = frt_out_r;

endmodule
`default_nettype wire

FILE: rtl/pid_with_feedforward_derivative.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        target, measured, integ_enable
// out_ch    out  valid/ready        drive, prop_term, deriv_term, integral_term,
//                                   target_rate_term, feedback_rate_term
// cfg_*     in   cfg_we, no stall   cfg_index, cfg_wdata
//
// An item passes from the accept cycle through the schedule steps to a load step that
// writes the result register. The nine Q16.16 products share one 33x33 multiplier,
// whose chain of dependent products sets the length of the schedule. Synchronous
// active-low reset clears all gains, history and integral. in_ch.ready is high only
// when idle; a result that out_ch has not taken holds the next item in the load step
// until the slot frees.
module pid_with_feedforward_derivative (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [pwfd_pkg::RegIdxW-1:0]      cfg_index,
  input  wire logic [pwfd_pkg::DataW-1:0]        cfg_wdata,
  pwfd_in_if.sink                                in_ch,
  pwfd_out_if.source                             out_ch
);

  pwfd_pkg::dp_cmd_t cmd;

  // sequencer: handshakes and the multiplier schedule
  pwfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: config registers, history, shared multiplier, result register
  pwfd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .target             (in_ch.target),
    .measured           (in_ch.measured),
    .integ_enable       (in_ch.integ_enable),
    .drive              (out_ch.drive),
    .prop_term          (out_ch.prop_term),
    .deriv_term         (out_ch.deriv_term),
    .integral_term      (out_ch.integral_term),
    .target_rate_term   (out_ch.target_rate_term),
    .feedback_rate_term (out_ch.feedback_rate_term)
  );

endmodule
`default_nettype wire
